// ----- rtl/sbh_pkg.sv -----
// sbh_pkg: constants, widths and state codes of the string bucket hash block.
// Pure package with no dependencies; used by string_bucket_hash.
package sbh_pkg;

    // Modulus width: only the low SIZE_BITS bits of table_size are used
    localparam int SIZE_BITS   = 16;

    // Field and bus widths
    localparam int CFG_W       = 16;
    localparam int CHAR_W      = 8;
    localparam int OUT_W       = 17;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;

    // Hash constants: the base 32 is applied as a left shift by 5
    localparam int HASH_OFFSET = 96;
    localparam int BASE_SHIFT  = 5;
    localparam int TABLE_RESET = 101;

    // Derived widths
    localparam int MOD_W  = SIZE_BITS;
    localparam int BIG_W  = (SIZE_BITS > CHAR_W) ? SIZE_BITS : CHAR_W;
    localparam int RV_W   = BIG_W + 1;            // signed running value
    localparam int MAG_W  = BIG_W + BASE_SHIFT + 1; // dividend magnitude
    localparam int A_W    = MAG_W + 1;            // signed dividend
    localparam int CNT_W  = $clog2(MAG_W);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

// ----- rtl/string_bucket_hash.sv -----
// string_bucket_hash: polynomial base-32 string hash reduced modulo a table size.
// Depends on sbh_pkg (widths, constants, state codes).
//
// A string streams in one character per word on s_axis (tdata[7:0] = character,
// tlast marks the last character). The first character of a longer string loads
// the running value with code-96. Every later character computes
// (value*32 + code-96) rem table_size, and a one-character string computes
// (code-96)*32 rem table_size, both with a truncating signed remainder; this
// runs on one restoring remainder unit that retires one dividend bit per cycle,
// so such a character passes an accept step, 22 divide steps and a finish step,
// and the block takes no new character until it is through. On the last
// character the 17-bit signed bucket index is placed in the output register on
// m_axis and the block re-arms. table_size is written over cfg_valid/cfg_data
// while the block is idle; an effective size of zero acts as one.
module string_bucket_hash (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration: table_size
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sbh_pkg::CFG_W-1:0]      cfg_data,
    // Input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [sbh_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // [7:0] char_code
    input  logic                           s_axis_tlast,   // last_char
    // Result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [sbh_pkg::M_TDATA_W-1:0]  m_axis_tdata    // [16:0] bucket_index, rest 0
);

    localparam int MOD_W = sbh_pkg::MOD_W;
    localparam int RV_W  = sbh_pkg::RV_W;
    localparam int MAG_W = sbh_pkg::MAG_W;
    localparam int A_W   = sbh_pkg::A_W;
    localparam int CNT_W = sbh_pkg::CNT_W;
    localparam int OUT_W = sbh_pkg::OUT_W;
    localparam int CFG_W = sbh_pkg::CFG_W;

    sbh_pkg::state_t            state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [MAG_W-1:0]           mag_reg, mag_next;
    logic                       neg_reg, neg_next;
    logic [MOD_W-1:0]           rem_reg, rem_next;
    logic                       last_reg, last_next;
    logic [RV_W-1:0]            rv_reg, rv_next;
    logic                       at_first_reg, at_first_next;
    logic [CFG_W-1:0]           size_reg, size_next;
    logic                       out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]           out_data_reg, out_data_next;

    logic                       accept;
    logic                       cfg_write;
    logic [CFG_W+MOD_W-1:0]     size_ext;
    logic [MOD_W-1:0]           m_raw;
    logic [MOD_W-1:0]           m_eff;
    logic [A_W-1:0]             code_a;
    logic [A_W-1:0]             rv_a;
    logic [A_W-1:0]             dividend;
    logic [A_W-1:0]             dividend_abs;
    logic [RV_W-1:0]            code_rv;
    logic [MOD_W:0]             rem_shift;
    logic                       rem_ge;
    logic [MOD_W:0]             rem_diff;
    logic [RV_W-1:0]            rem_rv;
    logic [RV_W-1:0]            res_rv;
    logic [RV_W+OUT_W-1:0]      res_wide;
    logic                       done_go;

    // Handshakes
    assign s_axis_tready = (state_reg == sbh_pkg::ST_IDLE);
    assign cfg_ready     = (state_reg == sbh_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_write     = cfg_valid && cfg_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(sbh_pkg::M_TDATA_W-OUT_W){1'b0}}, out_data_reg};

    // Effective modulus: low SIZE_BITS bits, zero acts as one
    assign size_ext = {{MOD_W{1'b0}}, size_reg};
    assign m_raw    = size_ext[MOD_W-1:0];
    assign m_eff    = (m_raw == '0) ? MOD_W'(1) : m_raw;

    // Dividend formed at accept: value*32 + code-96, or (code-96)*32 for a lone char
    assign code_a   = A_W'(s_axis_tdata[sbh_pkg::CHAR_W-1:0]) - A_W'(sbh_pkg::HASH_OFFSET);
    assign code_rv  = RV_W'(s_axis_tdata[sbh_pkg::CHAR_W-1:0]) - RV_W'(sbh_pkg::HASH_OFFSET);
    assign rv_a     = {{(A_W-RV_W){rv_reg[RV_W-1]}}, rv_reg};
    assign dividend = at_first_reg ? (code_a << sbh_pkg::BASE_SHIFT)
                                   : ((rv_a << sbh_pkg::BASE_SHIFT) + code_a);
    assign dividend_abs = dividend[A_W-1] ? (~dividend + A_W'(1)) : dividend;

    // Restoring remainder step: shift in one dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, mag_reg[MAG_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, m_eff});
    assign rem_diff  = rem_shift - {1'b0, m_eff};

    // Signed remainder follows the sign of the dividend
    assign rem_rv   = {{(RV_W-MOD_W){1'b0}}, rem_reg};
    assign res_rv   = neg_reg ? (~rem_rv + RV_W'(1)) : rem_rv;
    assign res_wide = {{OUT_W{res_rv[RV_W-1]}}, res_rv};

    // Finish may stall only when a result must go out and the output is full
    assign done_go = !last_reg || !out_valid_reg || m_axis_tready;

    // Sequencer and datapath next state
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        last_next      = last_reg;
        rv_next        = rv_reg;
        at_first_next  = at_first_reg;
        size_next      = cfg_write ? cfg_data : size_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;

        case (state_reg)
            sbh_pkg::ST_IDLE: begin
                if (accept) begin
                    last_next = s_axis_tlast;
                    if (at_first_reg && !s_axis_tlast) begin
                        // first of a longer string: load, no reduction
                        rv_next       = code_rv;
                        at_first_next = 1'b0;
                    end else begin
                        mag_next   = dividend_abs[MAG_W-1:0];
                        neg_next   = dividend[A_W-1];
                        rem_next   = '0;
                        cnt_next   = CNT_W'(MAG_W-1);
                        state_next = sbh_pkg::ST_DIV;
                    end
                end
            end
            sbh_pkg::ST_DIV: begin
                rem_next = rem_ge ? rem_diff[MOD_W-1:0] : rem_shift[MOD_W-1:0];
                mag_next = {mag_reg[MAG_W-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = sbh_pkg::ST_DONE;
                end
            end
            sbh_pkg::ST_DONE: begin
                if (done_go) begin
                    state_next = sbh_pkg::ST_IDLE;
                    if (last_reg) begin
                        out_valid_next = 1'b1;
                        out_data_next  = res_wide[OUT_W-1:0];
                        rv_next        = '0;
                        at_first_next  = 1'b1;
                    end else begin
                        rv_next       = res_rv;
                        at_first_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = sbh_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sbh_pkg::ST_IDLE;
            rv_reg        <= '0;
            at_first_reg  <= 1'b1;
            size_reg      <= CFG_W'(sbh_pkg::TABLE_RESET);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rv_reg        <= rv_next;
            at_first_reg  <= at_first_next;
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        rem_reg      <= rem_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    // Assertions
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !(at_first_reg && !s_axis_tlast))
            |=> (state_reg == sbh_pkg::ST_DIV) && (cnt_reg == CNT_W'(MAG_W-1)))
        else $error("divide did not start after accepted word");

    a_div_end: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == sbh_pkg::ST_DIV) && (cnt_reg == '0))
            |=> (state_reg == sbh_pkg::ST_DONE))
        else $error("divide did not finish after last step");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sbh_pkg::ST_DIV) |-> (rem_reg < m_eff))
        else $error("partial remainder not below modulus");

    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past((state_reg == sbh_pkg::ST_DONE) && last_reg))
        else $error("result word raised without a last character");

    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == sbh_pkg::ST_DONE) && last_reg && done_go)
            |=> at_first_reg && (rv_reg == '0) && out_valid_reg)
        else $error("block did not re-arm after emitting a result");

endmodule

// ----- tb/sv/tb_string_bucket_hash.sv -----
`timescale 1ns / 100ps
// tb_string_bucket_hash: self-checking testbench of the string bucket hash block.
// Depends on sbh_pkg and string_bucket_hash; strings are streamed in, every bucket
// index is predicted in the bench and compared with the word seen on m_axis.
module tb_string_bucket_hash;

    import sbh_pkg::*;

    localparam int DRAIN_CYCLES = 3 * (MAG_W + 2) + 10;  // block latency plus margin
    localparam int HOLD_CYCLES  = 400;                    // long receiver hold-off
    localparam int PHASE_CHARS  = 60;                     // least random characters per setting
    localparam int NUM_PHASES   = 8;
    localparam int RUN_W        = RV_W + 1;               // predictor running value

    // One pending input word: a character and its end-of-string mark
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              is_last;
    } char_word_t;

    // Kinds of random string content
    typedef enum int {
        TXT_LOWER,  // 'a'..'z'
        TXT_ANY,    // any byte
        TXT_BELOW   // bytes under the offset, drive the value negative
    } text_kind_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;  // [7:0] char_code
    logic                  s_axis_tlast  = 1'b0; // last_char
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;        // [16:0] bucket_index, rest 0

    // Stimulus and expected results
    char_word_t            char_q[$];
    logic [OUT_W-1:0]      bucket_q[$];

    // Predictor state and configuration
    logic [CFG_W-1:0]      tbl_size  = CFG_W'(TABLE_RESET);
    logic signed [RUN_W-1:0] run_val = '0;
    logic                  at_first  = 1'b1;

    // Idling control
    int                    tx_idle_pct = 34;
    int                    rx_idle_pct = 70;
    logic                  hold_go     = 1'b0;
    logic                  hold_fired  = 1'b0;
    int                    hold_cnt    = 0;

    // Counters
    int                    err_cnt     = 0;
    int                    chars_sent  = 0;
    int                    strings_hashed = 0;
    int                    buckets_checked = 0;
    int                    sizes_used  = 1;

    string_bucket_hash i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Advance the hash by one accepted character; queue the bucket on the last one
    function automatic void hash_char(input logic [CHAR_W-1:0] code, input logic is_last);
        longint delta;
        longint modulus;
        longint acc;
        longint bucket;
        delta   = longint'(code) - HASH_OFFSET;
        modulus = longint'(tbl_size) & ((longint'(1) << SIZE_BITS) - 1);
        if (modulus == 0) begin
            modulus = 1;  // zero size acts as one
        end
        if (at_first) begin
            run_val = RUN_W'(delta);  // first character loads without reduction
            if (!is_last) begin
                at_first = 1'b0;
                return;
            end
            acc    = longint'(run_val);
            bucket = (acc << BASE_SHIFT) % modulus;
        end else begin
            acc     = longint'(run_val);
            acc     = ((acc << BASE_SHIFT) + delta) % modulus;  // truncating remainder
            run_val = RUN_W'(acc);
            if (!is_last) begin
                return;
            end
            bucket = acc;
        end
        bucket_q.push_back(bucket[OUT_W-1:0]);
        strings_hashed++;
        run_val  = '0;
        at_first = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint exp_val,
                                   input longint got_val);
        $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what,
                 exp_val, got_val);
        err_cnt++;
    endtask

    // Driver: present the next pending word, predict on every accepted one
    always @(posedge aclk) begin
        char_word_t w;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                hash_char(s_axis_tdata[CHAR_W-1:0], s_axis_tlast);
                chars_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (char_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    w = char_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= S_TDATA_W'(w.code);
                    s_axis_tlast  <= w.is_last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result word against the oldest bucket
    always @(posedge aclk) begin
        logic [OUT_W-1:0] exp_bucket;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (bucket_q.size() == 0) begin
                report_mismatch("unexpected result word", 0, longint'(m_axis_tdata));
            end else begin
                exp_bucket = bucket_q.pop_front();
                if (m_axis_tdata[OUT_W-1:0] !== exp_bucket) begin
                    report_mismatch("bucket_index", longint'(exp_bucket),
                                    longint'(m_axis_tdata[OUT_W-1:0]));
                end
                if (m_axis_tdata[M_TDATA_W-1:OUT_W] !== '0) begin
                    report_mismatch("tdata padding", 0,
                                    longint'(m_axis_tdata[M_TDATA_W-1:OUT_W]));
                end
                buckets_checked++;
            end
        end
        m_axis_tready <= (hold_cnt == 0) && ($urandom_range(99) >= rx_idle_pct);
    end

    // Receiver hold-off, counted here once requested
    always @(posedge aclk) begin
        if (hold_go && !hold_fired) begin
            hold_cnt   <= HOLD_CYCLES;
            hold_fired <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    task automatic push_char(input int code, input bit is_last);
        char_word_t w;
        w.code    = CHAR_W'(code);
        w.is_last = is_last;
        char_q.push_back(w);
    endtask

    // Queue one string of the given length and content kind
    task automatic push_string(input int len, input text_kind_t kind);
        int code;
        for (int i = 0; i < len; i++) begin
            case (kind)
                TXT_LOWER: code = $urandom_range(122, 97);
                TXT_BELOW: code = $urandom_range(HASH_OFFSET - 1, 0);
                default:   code = $urandom_range(255, 0);
            endcase
            push_char(code, i == len - 1);
        end
    endtask

    // Wait until all words are in and out, then let the block finish any work
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (char_q.size() != 0 || s_axis_tvalid || bucket_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_table_size(input logic [CFG_W-1:0] size_val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= size_val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        tbl_size = size_val;
        sizes_used++;
    endtask

    // Main sequence: reset, directed strings, then random strings per table size
    initial begin
        logic [CFG_W-1:0] phase_size;
        int               n;
        int               len;
        int               dice;
        text_kind_t       kind;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed strings at the reset table size
        @(negedge aclk);
        push_char(0, 1);                      // lowest byte, one character: negative
        push_char(255, 1);                    // highest byte alone
        push_char(HASH_OFFSET, 1);            // offset itself hashes to zero
        push_char(97, 1);                     // single 'a'
        push_char(97, 0); push_char(98, 1);   // "ab"
        push_char(0, 0); push_char(0, 0); push_char(0, 1);
        push_char(255, 0); push_char(255, 0); push_char(255, 1);
        push_char(127, 0); push_char(128, 1);
        for (int i = 0; i < 5; i++) begin
            push_char(122, i == 4);           // "zzzzz"
        end
        push_char(95, 0); push_char(96, 1);   // just below and at the offset

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0:       phase_size = 16'hFFFF;                      // largest size
                1:       phase_size = 16'd2;                         // smallest size above one
                2:       phase_size = 16'd0;                         // zero acts as one
                3:       phase_size = 16'd1;                         // every index zero
                4:       phase_size = CFG_W'($urandom_range(40, 3));
                5:       phase_size = CFG_W'($urandom_range(65535, 2));
                6:       phase_size = 16'd32;                        // divides the base
                default: phase_size = CFG_W'($urandom_range(65535, 2));
            endcase
            write_table_size(phase_size);

            // Receiver idles most first, then sender, then neither
            if (ph < 3) begin
                tx_idle_pct <= 34;
                rx_idle_pct <= 70;
            end else if (ph < 6) begin
                tx_idle_pct <= 70;
                rx_idle_pct <= 34;
            end else begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end

            @(negedge aclk);
            n = 0;
            while (n < PHASE_CHARS) begin
                len  = ($urandom_range(99) < 85) ? $urandom_range(6, 1) : $urandom_range(20, 7);
                dice = $urandom_range(99);
                kind = (dice < 70) ? TXT_LOWER : (dice < 85) ? TXT_ANY : TXT_BELOW;
                push_string(len, kind);
                n += len;
            end
            // Stall the output while the sender keeps offering
            if (ph == 6) begin
                hold_go <= 1'b1;
            end
        end

        wait_drained();
        $display("Hashed %0d strings from %0d characters across %0d table sizes.",
                 strings_hashed, chars_sent, sizes_used);
        $display("Checked %0d bucket words, %0d mismatches.", buckets_checked, err_cnt);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Timeout: %0d words pending, %0d buckets outstanding",
                 char_q.size(), bucket_q.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/sbh_pkg.sv
rtl/string_bucket_hash.sv
tb/sv/tb_string_bucket_hash.sv
